// File: rtl/gnnr_pkg.sv
// ----------------------------------------------------------------------------
// gnnr_pkg
// Shared types and constants of the greedy nearest-neighbor route builder.
// ----------------------------------------------------------------------------
package gnnr_pkg;

	localparam int MAX_NODES    = 32;
	localparam int MAX_VEHICLES = 8;
	localparam int NODE_W       = $clog2(MAX_NODES);
	localparam int NN_W         = NODE_W + 1;
	localparam int VEH_W        = $clog2(MAX_VEHICLES);
	localparam int NV_W         = 4;
	localparam int DIST_W       = 16;
	localparam int DEM_W        = 8;
	localparam int COST_W       = 24;
	localparam int DADDR_W      = 2 * NODE_W;
	localparam int DIST_DEPTH   = MAX_NODES * MAX_NODES;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 8;

	localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

	typedef enum logic [1:0] {
		REQ_DEMAND = 2'd0,
		REQ_DIST   = 2'd1,
		REQ_RUN    = 2'd2
	} req_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CAPACITY = 2'd0,
		CFG_VEHICLES = 2'd1,
		CFG_NODES    = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH,
		ST_DECIDE
	} seq_state_t;

	typedef struct packed {
		logic [DEM_W-1:0] capacity;
		logic [NV_W-1:0]  vehicle_count;
		logic [NN_W-1:0]  node_count;
	} cfg_t;

	typedef struct packed {
		logic [VEH_W-1:0]  vehicle_id;
		logic [NODE_W-1:0] to_node;
		logic [DIST_W-1:0] leg_distance;
		logic [COST_W-1:0] vehicle_cost;
		logic [DEM_W-1:0]  load_left;
		logic              all_served;
		logic              last_result;
	} result_t;

endpackage

// File: rtl/gnnr_ram.sv
// ----------------------------------------------------------------------------
// gnnr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gnnr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/gnnr_seq.sv
// ----------------------------------------------------------------------------
// gnnr_seq
// Route sequencer: scans candidate nodes through one compare unit, one per
// cycle, then commits the pick or the depot return.
// ----------------------------------------------------------------------------
module gnnr_seq (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              run_start,
	input  gnnr_pkg::cfg_t                    cfg,
	input  logic [gnnr_pkg::DIST_W-1:0]       dist_rd,
	input  logic [gnnr_pkg::DEM_W-1:0]        dem_rd,
	input  logic                              slot_free,
	output logic                              busy,
	output logic [gnnr_pkg::DADDR_W-1:0]      dist_raddr,
	output logic [gnnr_pkg::NODE_W-1:0]       dem_raddr,
	output logic                              emit,
	output gnnr_pkg::result_t                 emit_res
);
	import gnnr_pkg::*;

	seq_state_t state_q, state_d;

	logic [NODE_W-1:0]    j_q;
	logic [NODE_W-1:0]    j_s1;
	logic                 valid_s1;
	logic [NN_W-1:0]      nn_q;
	logic [NV_W-1:0]      nv_q;
	logic [VEH_W-1:0]     v_q;
	logic [NODE_W-1:0]    cur_q;
	logic [DEM_W-1:0]     load_q;
	logic [COST_W-1:0]    cost_q;
	logic [MAX_NODES-1:0] visited_q;
	logic                 found_q;
	logic [NODE_W-1:0]    best_q;
	logic [DIST_W-1:0]    bestd_q;
	logic [DEM_W-1:0]     bestdem_q;

	logic                 last_scan;
	logic                 last_veh;
	logic                 cand;
	logic [DIST_W-1:0]    add_d;
	logic [COST_W:0]      sum;
	logic [COST_W-1:0]    new_cost;
	logic                 unserved;
	logic [NN_W-1:0]      nn_in;
	logic [NV_W-1:0]      nv_in;

	assign last_scan = ({1'b0, j_q} == nn_q - NN_W'(1));
	assign last_veh  = ({1'b0, v_q} + NV_W'(1)) == nv_q;
	assign cand      = valid_s1 && !visited_q[j_s1] && (dem_rd <= load_q) &&
			(!found_q || (dist_rd < bestd_q));
	assign add_d     = found_q ? bestd_q : dist_rd;
	assign sum       = {1'b0, cost_q} + (COST_W+1)'(add_d);
	assign new_cost  = sum[COST_W] ? COST_MAX : sum[COST_W-1:0];

	always_comb begin
		nn_in = cfg.node_count;
		if (cfg.node_count == '0) begin
			nn_in = NN_W'(1);
		end else if (cfg.node_count > NN_W'(MAX_NODES)) begin
			nn_in = NN_W'(MAX_NODES);
		end
		nv_in = cfg.vehicle_count;
		if (cfg.vehicle_count == '0) begin
			nv_in = NV_W'(1);
		end else if (cfg.vehicle_count > NV_W'(MAX_VEHICLES)) begin
			nv_in = NV_W'(MAX_VEHICLES);
		end
	end

	always_comb begin
		unserved = 1'b0;
		for (int i = 0; i < MAX_NODES; i++) begin
			if (!visited_q[i] && (NN_W'(i) < nn_q)) begin
				unserved = 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (run_start) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (last_scan) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (slot_free) begin
					if (found_q || !last_veh) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy       = (state_q != ST_IDLE);
		dist_raddr = (state_q == ST_SCAN) ? {cur_q, j_q} : {cur_q, NODE_W'(0)};
		dem_raddr  = j_q;
		emit       = (state_q == ST_DECIDE) && slot_free;
		emit_res.vehicle_id   = v_q;
		emit_res.vehicle_cost = new_cost;
		if (found_q) begin
			emit_res.to_node      = best_q;
			emit_res.leg_distance = bestd_q;
			emit_res.load_left    = load_q - bestdem_q;
			emit_res.all_served   = 1'b0;
			emit_res.last_result  = 1'b0;
		end else begin
			emit_res.to_node      = '0;
			emit_res.leg_distance = dist_rd;
			emit_res.load_left    = load_q;
			emit_res.all_served   = last_veh && !unserved;
			emit_res.last_result  = last_veh;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			j_q       <= '0;
			j_s1      <= '0;
			valid_s1  <= 1'b0;
			nn_q      <= NN_W'(1);
			nv_q      <= NV_W'(1);
			v_q       <= '0;
			cur_q     <= '0;
			load_q    <= '0;
			cost_q    <= '0;
			visited_q <= '0;
			found_q   <= 1'b0;
			best_q    <= '0;
			bestd_q   <= '0;
			bestdem_q <= '0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= (state_q == ST_SCAN);
			j_s1     <= j_q;
			if (cand) begin
				found_q   <= 1'b1;
				best_q    <= j_s1;
				bestd_q   <= dist_rd;
				bestdem_q <= dem_rd;
			end
			case (state_q)
				ST_IDLE: begin
					if (run_start) begin
						nn_q      <= nn_in;
						nv_q      <= nv_in;
						v_q       <= '0;
						cur_q     <= '0;
						load_q    <= cfg.capacity;
						cost_q    <= '0;
						visited_q <= MAX_NODES'(1);
						j_q       <= '0;
						found_q   <= 1'b0;
					end
				end
				ST_SCAN: begin
					j_q <= j_q + NODE_W'(1);
				end
				ST_DECIDE: begin
					if (slot_free) begin
						j_q     <= '0;
						found_q <= 1'b0;
						if (found_q) begin
							load_q            <= load_q - bestdem_q;
							cost_q            <= new_cost;
							visited_q[best_q] <= 1'b1;
							cur_q             <= best_q;
						end else if (!last_veh) begin
							v_q    <= v_q + VEH_W'(1);
							cur_q  <= '0;
							load_q <= cfg.capacity;
							cost_q <= '0;
						end else begin
							cost_q <= new_cost;
							cur_q  <= '0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// File: rtl/greedy_nearest_neighbor_routing.sv
// ----------------------------------------------------------------------------
// greedy_nearest_neighbor_routing
// Capacitated vehicle route builder by nearest-neighbor greedy choice.
// ----------------------------------------------------------------------------
// Demand and distance load transactions are accepted back to back while no
// run is in progress. A run transaction holds in_stall high until the run is
// done: every pick and every depot return scans the candidates one per cycle
// through the distance RAM read port and a single comparator, and the run
// also waits whenever out_stall holds a result. Legs come out in route order,
// and the last one carries last_result and the all-served flag.
module greedy_nearest_neighbor_routing (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [1:0]                           req_type,
	input  logic [4:0]                           row_node,
	input  logic [4:0]                           col_node,
	input  logic [15:0]                          item_value,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [2:0]                           vehicle_id,
	output logic [4:0]                           to_node,
	output logic [15:0]                          leg_distance,
	output logic [23:0]                          vehicle_cost,
	output logic [7:0]                           load_left,
	output logic                                 all_served,
	output logic                                 last_result,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [gnnr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [gnnr_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import gnnr_pkg::*;

	cfg_t                cfg_q;
	result_t             out_res_q;
	logic                out_valid_q;
	logic                in_acc;
	logic                busy;
	logic                slot_free;
	logic                emit;
	result_t             emit_res;
	logic [DADDR_W-1:0]  dist_raddr;
	logic [NODE_W-1:0]   dem_raddr;
	logic [DIST_W-1:0]   dist_rd;
	logic [DEM_W-1:0]    dem_rd;

	assign cfg_ready = 1'b1;
	assign in_stall  = busy;
	assign in_acc    = in_valid && !busy;
	assign slot_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.capacity      <= '0;
			cfg_q.vehicle_count <= NV_W'(1);
			cfg_q.node_count    <= NN_W'(MAX_NODES);
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_CAPACITY: cfg_q.capacity      <= cfg_data[DEM_W-1:0];
				CFG_VEHICLES: cfg_q.vehicle_count <= cfg_data[NV_W-1:0];
				CFG_NODES:    cfg_q.node_count    <= cfg_data[NN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	gnnr_ram #(
		.WIDTH(DIST_W),
		.DEPTH(DIST_DEPTH)
	) u_dist_ram (
		.clk  (clk),
		.we   (in_acc && (req_type == REQ_DIST)),
		.waddr({row_node, col_node}),
		.wdata(item_value[DIST_W-1:0]),
		.raddr(dist_raddr),
		.rdata(dist_rd)
	);

	gnnr_ram #(
		.WIDTH(DEM_W),
		.DEPTH(MAX_NODES)
	) u_dem_ram (
		.clk  (clk),
		.we   (in_acc && (req_type == REQ_DEMAND)),
		.waddr(row_node),
		.wdata(item_value[DEM_W-1:0]),
		.raddr(dem_raddr),
		.rdata(dem_rd)
	);

	gnnr_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.run_start (in_acc && (req_type == REQ_RUN)),
		.cfg       (cfg_q),
		.dist_rd   (dist_rd),
		.dem_rd    (dem_rd),
		.slot_free (slot_free),
		.busy      (busy),
		.dist_raddr(dist_raddr),
		.dem_raddr (dem_raddr),
		.emit      (emit),
		.emit_res  (emit_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_res_q <= emit_res;
		end
	end

	assign out_valid    = out_valid_q;
	assign vehicle_id   = out_res_q.vehicle_id;
	assign to_node      = out_res_q.to_node;
	assign leg_distance = out_res_q.leg_distance;
	assign vehicle_cost = out_res_q.vehicle_cost;
	assign load_left    = out_res_q.load_left;
	assign all_served   = out_res_q.all_served;
	assign last_result  = out_res_q.last_result;

endmodule

// File: rtl/gnnr_checker.sv
// ----------------------------------------------------------------------------
// gnnr_checker
// Port-level checks of the route builder, bound to the top level.
// ----------------------------------------------------------------------------
module gnnr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  req_type,
	input logic        out_valid,
	input logic        out_stall,
	input logic [4:0]  to_node,
	input logic [23:0] vehicle_cost,
	input logic        all_served,
	input logic        last_result
);
	import gnnr_pkg::*;

	// hold a stalled result transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(to_node) &&
			$stable(vehicle_cost) && $stable(last_result))
		else $error("stalled result transaction changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_result |-> to_node == '0)
		else $error("final leg is not a depot return");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && all_served |-> last_result)
		else $error("all_served set on a non-final leg");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid) && ($past(req_type) == REQ_RUN))
		else $error("busy without a run transaction");

endmodule

bind greedy_nearest_neighbor_routing gnnr_checker u_gnnr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.req_type    (req_type),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.to_node     (to_node),
	.vehicle_cost(vehicle_cost),
	.all_served  (all_served),
	.last_result (last_result)
);
